@@ rtl/core/substring_match_finder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the substring match finder
// Wrappers that give every concurrent check the same clocking and report form.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_MATCH_FINDER_MACROS_SVH
`define SUBSTRING_MATCH_FINDER_MACROS_SVH

// Same-cycle implication, disabled while the given reset term is high.
`define SMF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the given reset term is high.
`define SMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/smf_pkg.sv @@
// ----------------------------------------------------------------------------
// Substring match finder package
// Sizes, configuration register indexes and the item passed between front
// and back.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int INDEX_BITS  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int BYTE_W    = 8;
  localparam int CFG_LEN_W = 5;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int MATCH_W   = 17;
  localparam int PAT_W     = MAX_PATTERN * BYTE_W;
  localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
  localparam int PAT_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [INDEX_BITS-1:0] COUNT_MAX = {INDEX_BITS{1'b1}};
  localparam logic [MATCH_W-1:0]    NO_MATCH  = {MATCH_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                  hit;
    logic                  last;
    logic [INDEX_BITS-1:0] pos;
  } item_t;

  function automatic logic [LEN_W-1:0] used_length(input logic [CFG_LEN_W-1:0] pl);
    priority if (pl == '0) begin
      return LEN_W'(1);
    end else if (pl > CFG_LEN_W'(MAX_PATTERN)) begin
      return LEN_W'(MAX_PATTERN);
    end else begin
      return LEN_W'(pl);
    end
  endfunction

endpackage

@@ rtl/core/smf_front.sv @@
// ----------------------------------------------------------------------------
// Substring match finder front end
// Takes text bytes, shifts the byte window, compares it with the pattern and
// writes one classified item per byte into the queue.
// ----------------------------------------------------------------------------
module smf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic                              full,
  input  logic [smf_pkg::BYTE_W-1:0]        text_byte,
  input  logic                              end_of_text,
  input  logic [smf_pkg::LEN_W-1:0]         used_len,
  input  logic [smf_pkg::PAT_W-1:0]         pattern_bits,
  output logic                              q_write,
  output smf_pkg::item_t                    q_item
);
  import smf_pkg::*;

  logic [BYTE_W-1:0]     window      [MAX_PATTERN];
  logic [BYTE_W-1:0]     window_next [MAX_PATTERN];
  logic [BYTE_W-1:0]     pat         [MAX_PATTERN];
  logic [LEN_W-1:0]      pat_sel     [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] byte_ok;
  logic [INDEX_BITS-1:0] byte_count;
  logic                  enough;
  logic                  accept;

  assign accept = push && !full;

  always_comb begin
    window_next[0] = text_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      window_next[i] = window[i-1];
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat[k] = pattern_bits[k*BYTE_W +: BYTE_W];
    end
    // The newest byte sits at window entry 0 and meets the last pattern byte.
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_sel[i] = used_len - LEN_W'(1) - LEN_W'(i);
      byte_ok[i] = (LEN_W'(i) >= used_len) ||
                   (window_next[i] == pat[pat_sel[i][PAT_IDX_W-1:0]]);
    end
  end

  assign enough = ({1'b0, byte_count} + (INDEX_BITS+1)'(1)) >=
                  (INDEX_BITS+1)'(used_len);

  assign q_write     = accept;
  assign q_item.hit  = enough && (&byte_ok);
  assign q_item.last = end_of_text;
  assign q_item.pos  = byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window[i] <= '0;
      end
    end else if (accept) begin
      if (end_of_text) begin
        byte_count <= '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
          window[i] <= '0;
        end
      end else begin
        if (byte_count != COUNT_MAX) begin
          byte_count <= byte_count + INDEX_BITS'(1);
        end
        for (int i = 0; i < MAX_PATTERN; i++) begin
          window[i] <= window_next[i];
        end
      end
    end
  end

endmodule

@@ rtl/core/smf_queue.sv @@
// ----------------------------------------------------------------------------
// Substring match finder item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module smf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  smf_pkg::item_t wr_item,
  output logic           full,
  input  logic           rd_en,
  output smf_pkg::item_t rd_item,
  output logic           empty
);
  import smf_pkg::*;

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/smf_back.sv @@
// ----------------------------------------------------------------------------
// Substring match finder back end
// Turns queued items into results, tracks whether the text had any match and
// holds the result register seen on the output ports.
// ----------------------------------------------------------------------------
module smf_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  smf_pkg::item_t                    q_item,
  output logic                              q_read,
  input  logic [smf_pkg::LEN_W-1:0]         used_len,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [smf_pkg::MATCH_W-1:0] match_start,
  output logic                              done_res
);
  import smf_pkg::*;

  logic                  out_valid;
  logic                  found_any;
  logic                  take;
  logic                  produce;
  logic [INDEX_BITS:0]   start_full;
  logic [MATCH_W-1:0]    result_value;

  assign take    = !q_empty && (!out_valid || pop);
  assign q_read  = take;
  assign produce = q_item.hit || (q_item.last && !found_any);
  assign empty   = !out_valid;

  assign start_full   = {1'b0, q_item.pos} + (INDEX_BITS+1)'(1) -
                        (INDEX_BITS+1)'(used_len);
  assign result_value = q_item.hit ? MATCH_W'(start_full) : NO_MATCH;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      found_any <= 1'b0;
    end else if (take) begin
      found_any <= q_item.last ? 1'b0 : (found_any || q_item.hit);
      if (produce) begin
        out_valid   <= 1'b1;
        match_start <= $signed(result_value);
        done_res    <= q_item.last;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/substring_match_finder.sv @@
// ----------------------------------------------------------------------------
// Substring match finder
// Streaming search of a text for a configured pattern of 1 to 16 bytes.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle while full is low and
// reports the start index of every occurrence of the pattern, overlapping
// ones included, in text order. The byte marked end_of_text closes the text;
// if the text held no match, it gives a result of -1 with done_res set. The
// front end compares the full window in the accept cycle and writes its item
// into a four-entry queue, which feeds the back end's result register on the
// output ports. The queue lets input keep flowing while results wait to be
// popped.
// Configuration is taken on any cycle and must only change while the block is
// idle.
module substring_match_finder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [smf_pkg::BYTE_W-1:0]          text_byte,
  input  logic                                end_of_text,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [smf_pkg::MATCH_W-1:0]  match_start,
  output logic                                done_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smf_pkg::CFG_W-1:0]           cfg_data
);
  import smf_pkg::*;

  logic [CFG_LEN_W-1:0] pattern_length;
  logic [CFG_W-1:0]     pattern_low_bytes;
  logic [CFG_W-1:0]     pattern_high_bytes;
  logic [LEN_W-1:0]     used_len;
  logic [PAT_W-1:0]     pattern_bits;
  logic                 q_write;
  logic                 q_read;
  logic                 q_empty;
  item_t                wr_item;
  item_t                rd_item;

  assign cfg_ready    = 1'b1;
  assign used_len     = used_length(pattern_length);
  assign pattern_bits = PAT_W'({pattern_high_bytes, pattern_low_bytes});

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= CFG_LEN_W'(1);
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length     <= cfg_data[CFG_LEN_W-1:0];
        REG_PATTERN_LOW:    pattern_low_bytes  <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  smf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .used_len     (used_len),
    .pattern_bits (pattern_bits),
    .q_write      (q_write),
    .q_item       (wr_item)
  );

  smf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_write),
    .wr_item (wr_item),
    .full    (full),
    .rd_en   (q_read),
    .rd_item (rd_item),
    .empty   (q_empty)
  );

  smf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_item      (rd_item),
    .q_read      (q_read),
    .used_len    (used_len),
    .pop         (pop),
    .empty       (empty),
    .match_start (match_start),
    .done_res    (done_res)
  );

endmodule

@@ rtl/core/smf_checker.sv @@
// ----------------------------------------------------------------------------
// Substring match finder port checker
// Watches the top-level ports for reset behavior, held results and the form
// of the no-match result.
// ----------------------------------------------------------------------------
`include "substring_match_finder_macros.svh"

module smf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic signed [smf_pkg::MATCH_W-1:0]  match_start,
  input logic                                done_res
);
  import smf_pkg::*;

  `SMF_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, empty && !full, "reset left results or a full queue")
  `SMF_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(match_start) && $stable(done_res), "waiting result changed before transfer")
  `SMF_ASSERT_NOW(a_no_match_closes, clk, rst, !empty && (match_start == $signed(NO_MATCH)), done_res, "no-match result without done flag")

endmodule

bind substring_match_finder smf_checker u_smf_checker (.*);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the substring match finder
// A directed table followed by random texts over many pattern settings, each
// result checked against its typed table row or a software search of the text.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 100;

  typedef struct {
    logic signed [MATCH_W-1:0] start;
    logic                      done;
  } match_t;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  // On byte rows the text byte sits in the low bits of data and index is unused.
  typedef struct packed {
    row_kind_t          kind;
    cfg_reg_t           index;
    logic [CFG_W-1:0]   data;
    logic               last;
    logic               typed;
    logic               typed_hit;
    logic [MATCH_W-1:0] typed_start;
    logic               typed_done;
  } plan_row_t;

  localparam int PLAN_ROWS = 31;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h00, 1'b0, 1'b1, 1'b1, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'hFF, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'hFF, 1'b1, 1'b1, 1'b1, NO_MATCH, 1'b1},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h00, 1'b1, 1'b1, 1'b1, 17'd0, 1'b1},
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'h00, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_WRITE, REG_PATTERN_LOW,    64'h41, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h41, 1'b0, 1'b1, 1'b1, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h41, 1'b1, 1'b1, 1'b1, 17'd1, 1'b1},
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF,
      1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_WRITE, REG_PATTERN_LOW,    64'h0706_0504_0302_01FF,
      1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_WRITE, REG_PATTERN_HIGH,   64'h00F0_E0D0_C0B0_A090,
      1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'hFF, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h01, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h02, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h03, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h04, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h05, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h06, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h07, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h90, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'hA0, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'hB0, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'hC0, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'hD0, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'hE0, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'hF0, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h00, 1'b1, 1'b1, 1'b1, 17'd0, 1'b1},
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'h03, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_WRITE, REG_PATTERN_LOW,    64'h00, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h00, 1'b0, 1'b1, 1'b0, 17'd0, 1'b0},
    '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'h00, 1'b1, 1'b1, 1'b1, NO_MATCH, 1'b1}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  logic [BYTE_W-1:0]         text_byte = '0;
  logic                      end_of_text = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic signed [MATCH_W-1:0] match_start;
  logic                      done_res;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;

  logic [BYTE_W-1:0]     recent_bytes [MAX_PATTERN];
  logic [INDEX_BITS-1:0] text_pos;
  logic                  seen_match;
  logic [CFG_LEN_W-1:0]  pat_len_reg;
  logic [CFG_W-1:0]      pat_low_reg;
  logic [CFG_W-1:0]      pat_high_reg;

  match_t      pending_starts [$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  bit          steady = 1'b0;
  bit          narrow = 1'b0;
  logic [7:0]  alpha_base = '0;

  substring_match_finder i_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .empty       (empty),
    .pop         (pop),
    .match_start (match_start),
    .done_res    (done_res),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned active_length();
    if (pat_len_reg == '0) begin
      return 1;
    end
    if (pat_len_reg > CFG_LEN_W'(MAX_PATTERN)) begin
      return MAX_PATTERN;
    end
    return pat_len_reg;
  endfunction

  function automatic void clear_text();
    foreach (recent_bytes[i]) recent_bytes[i] = '0;
    text_pos = '0;
    seen_match = 1'b0;
  endfunction

  function automatic void find_match_end(input logic [BYTE_W-1:0] b, input logic last,
                                         output bit produced, output match_t res);
    int unsigned      len;
    int unsigned      pos;
    int unsigned      k;
    logic [PAT_W-1:0] pat;
    bit               hit;
    len = active_length();
    pos = text_pos;
    pat = {pat_high_reg, pat_low_reg};
    for (k = MAX_PATTERN - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
    recent_bytes[0] = b;
    hit = (pos + 1 >= len);
    for (k = 0; hit && k < len; k++) begin
      if (recent_bytes[len - 1 - k] != pat[8 * k +: 8]) hit = 1'b0;
    end
    produced = hit || (last && !seen_match);
    res.start = hit ? MATCH_W'(pos + 1 - len) : NO_MATCH;
    res.done = last;
    if (hit) seen_match = 1'b1;
    if (text_pos != COUNT_MAX) text_pos++;
    if (last) clear_text();
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                           output bit produced, output match_t res);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 11) begin
      push <= 1'b0;
      text_byte <= BYTE_W'($urandom_range(255));
      end_of_text <= 1'($urandom_range(1));
      @(negedge clk);
    end
    push <= 1'b1;
    text_byte <= b;
    end_of_text <= last;
    do @(posedge clk); while (full);
    find_match_end(b, last, produced, res);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    push <= 1'b0;
    while (pending_starts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_LENGTH: pat_len_reg = value[CFG_LEN_W-1:0];
      REG_PATTERN_LOW:    pat_low_reg = value;
      REG_PATTERN_HIGH:   pat_high_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_text(input int target, input int plant_pct);
    logic [BYTE_W-1:0] bytes_q [$];
    logic [PAT_W-1:0]  pat;
    int unsigned       used;
    int                k;
    int                pick;
    bit                produced;
    match_t            res;
    used = active_length();
    pat = {pat_high_reg, pat_low_reg};
    while (bytes_q.size() < target) begin
      if ($urandom_range(99) < plant_pct) begin
        for (k = 0; k < used; k++) bytes_q.push_back(pat[8 * k +: 8]);
        if ($urandom_range(4) == 0) begin
          pick = bytes_q.size() - 1 - $urandom_range(used - 1);
          bytes_q[pick] ^= BYTE_W'(1 << $urandom_range(7));
        end
      end else if (narrow && $urandom_range(9) != 0) begin
        bytes_q.push_back(alpha_base | BYTE_W'($urandom_range(1)));
      end else begin
        bytes_q.push_back(BYTE_W'($urandom_range(255)));
      end
    end
    foreach (bytes_q[i]) begin
      send_byte(bytes_q[i], i == bytes_q.size() - 1, produced, res);
      if (produced) pending_starts.push_back(res);
    end
  endtask

  initial begin : result_side
    int     hold_left;
    bit     hold_done;
    match_t want;
    hold_left = 0;
    hold_done = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!hold_done && results_checked >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= 11);
      end
      @(posedge clk);
      if (pop && !empty) begin
        if (pending_starts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, match_start %0d done_res %0b",
                   $time, match_start, done_res);
        end else begin
          want = pending_starts.pop_front();
          if (match_start !== want.start) begin
            errors++;
            $display("%0t: match_start expected %0d, got %0d", $time, want.start, match_start);
          end
          if (done_res !== want.done) begin
            errors++;
            $display("%0t: done_res expected %0b, got %0b", $time, want.done, done_res);
          end
          results_checked++;
        end
      end
    end
  end

  // The longest quiet stretch in a correct run is the receiver hold-off.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int                   r;
    int                   phase;
    int                   k;
    int                   plant_pct;
    int                   phase_end;
    logic [CFG_LEN_W-1:0] len_code;
    logic [CFG_W-1:0]     value;
    logic [PAT_W-1:0]     pattern_pick;
    bit                   produced;
    match_t               res;

    pat_len_reg = CFG_LEN_W'(1);
    pat_low_reg = '0;
    pat_high_reg = '0;
    clear_text();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        write_reg(PLAN[r].index, PLAN[r].data);
      end else begin
        send_byte(PLAN[r].data[BYTE_W-1:0], PLAN[r].last, produced, res);
        if (PLAN[r].typed) begin
          produced = PLAN[r].typed_hit;
          res.start = PLAN[r].typed_start;
          res.done = PLAN[r].typed_done;
        end
        if (produced) pending_starts.push_back(res);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady = (phase == 6 || phase == 7);
      case (phase)
        0: begin
          len_code = CFG_LEN_W'(16);
        end
        1: begin
          len_code = CFG_LEN_W'(1);
        end
        2: begin
          len_code = CFG_LEN_W'(31);
        end
        3: begin
          len_code = '0;
        end
        default: begin
          if ($urandom_range(99) < 70) len_code = CFG_LEN_W'($urandom_range(1, 6));
          else len_code = CFG_LEN_W'($urandom_range(31));
        end
      endcase
      narrow = 1'($urandom_range(1));
      alpha_base = BYTE_W'($urandom_range(255)) & 8'hFE;
      for (k = 0; k < MAX_PATTERN; k++) begin
        if (narrow) pattern_pick[8 * k +: 8] = alpha_base | BYTE_W'($urandom_range(1));
        else pattern_pick[8 * k +: 8] = BYTE_W'($urandom_range(255));
      end
      value = {$urandom, $urandom};
      value[CFG_LEN_W-1:0] = len_code;
      write_reg(REG_PATTERN_LENGTH, value);
      write_reg(REG_PATTERN_LOW, pattern_pick[CFG_W-1:0]);
      write_reg(REG_PATTERN_HIGH, pattern_pick[PAT_W-1:CFG_W]);
      if (phase == 5) write_reg(REG_UNUSED, {$urandom, $urandom});
      plant_pct = $urandom_range(15, 50);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        send_text($urandom_range(1, 3 * active_length() + 8), plant_pct);
      end
    end
    steady = 1'b0;

    @(negedge clk);
    push <= 1'b0;
    while (pending_starts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
